FILE: sv/isp_pkg.sv
`timescale 1ns / 1ps
// Irrigation pump sequencer: shared types and constants.
// No dependencies; compiled first.
package isp_pkg;

  // Fixed field widths of the channels
  localparam int unsigned NOW_W   = 32;
  localparam int unsigned LVL_W   = 8;
  localparam int unsigned SEC_W   = 16;
  localparam int unsigned MS_W    = 26;  // 65535 s in ms fits in 26 bits
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned MAX_RES = 3;

  localparam logic [MS_W-1:0]  MS_PER_S      = MS_W'(1000);
  localparam logic [MS_W-1:0]  CHECK_MS      = MS_W'(200);
  localparam logic [CFG_W-1:0] VAL_PERIOD_RST = CFG_W'(1000);

  // Register indexes
  localparam logic [CIDX_W-1:0] REG_ENABLE     = 3'd0;
  localparam logic [CIDX_W-1:0] REG_MODE       = 3'd1;
  localparam logic [CIDX_W-1:0] REG_ON_TIME    = 3'd2;
  localparam logic [CIDX_W-1:0] REG_OFF_TIME   = 3'd3;
  localparam logic [CIDX_W-1:0] REG_SWING_TIME = 3'd4;
  localparam logic [CIDX_W-1:0] REG_FLOOD_TIME = 3'd5;
  localparam logic [CIDX_W-1:0] REG_MIN_LEVEL  = 3'd6;
  localparam logic [CIDX_W-1:0] REG_VAL_PERIOD = 3'd7;

  // Operating modes
  localparam logic [2:0] MODE_NORMAL = 3'd0;
  localparam logic [2:0] MODE_SWING  = 3'd1;
  localparam logic [2:0] MODE_DRIP   = 3'd2;
  localparam logic [2:0] MODE_MAINT  = 3'd3;
  localparam logic [2:0] MODE_DAM    = 3'd4;

  // Input word kinds
  localparam logic [1:0] FUNC_TICK    = 2'd0;
  localparam logic [1:0] FUNC_LOWER   = 2'd1;
  localparam logic [1:0] FUNC_UPPER   = 2'd2;
  localparam logic [1:0] FUNC_RESTART = 2'd3;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_PUMP_OFF  = 3'd1,
    ACT_PUMP_ON   = 3'd2,
    ACT_DAM_OPEN  = 3'd3,
    ACT_DAM_CLOSE = 3'd4
  } isp_act_e;

  typedef struct packed {
    logic [1:0]       func;
    logic [NOW_W-1:0] now_ms;
    logic [LVL_W-1:0] water_level;
    logic             pump_running;
    logic             float_high;
    logic             lower_present;
    logic             upper_present;
    logic             system_ready;
  } isp_in_t;

  typedef struct packed {
    isp_act_e action;
    logic     pump_not_operate;
    logic     tank_flood_late;
    logic     device_mismatch;
    logic     last;
  } isp_out_t;

  typedef struct packed {
    logic pno;
    logic late;
    logic dm;
  } isp_flags_t;

  // Register file contents, durations already scaled to ms
  typedef struct packed {
    logic             enable;
    logic [2:0]       mode;
    logic [MS_W-1:0]  on_ms;
    logic [MS_W-1:0]  off_ms;
    logic [MS_W-1:0]  swing_ms;
    logic [MS_W-1:0]  flood_ms;
    logic [LVL_W-1:0] min_level;
    logic [CFG_W-1:0] val_period;
  } isp_cfg_t;

  // Up to three commands of one item, with the flags after the item
  typedef struct packed {
    logic [MAX_RES-1:0][2:0] acts;
    logic [1:0]              cnt;
    isp_flags_t              flags;
  } isp_bundle_t;

endpackage

FILE: sv/isp_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input and result words.
// Depends on isp_pkg.
interface isp_in_if;
  logic            valid;
  logic            ready;
  isp_pkg::isp_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface isp_out_if;
  logic              valid;
  logic              ready;
  isp_pkg::isp_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/isp_cfg.sv
`timescale 1ns / 1ps
// Configuration register file; second values are scaled to ms on write.
// Depends on isp_pkg.
module isp_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [isp_pkg::CIDX_W-1:0] cfg_idx_i,
  input  logic [isp_pkg::CFG_W-1:0]  cfg_wdata_i,
  output isp_pkg::isp_cfg_t          cfg_o
);
  import isp_pkg::*;

  isp_cfg_t        cfg_q;
  logic [MS_W-1:0] wdata_ms;

  assign wdata_ms = MS_W'(cfg_wdata_i) * MS_PER_S;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q            <= '0;
      cfg_q.val_period <= VAL_PERIOD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ENABLE:     cfg_q.enable     <= cfg_wdata_i[0];
        REG_MODE:       cfg_q.mode       <= cfg_wdata_i[2:0];
        REG_ON_TIME:    cfg_q.on_ms      <= wdata_ms;
        REG_OFF_TIME:   cfg_q.off_ms     <= wdata_ms;
        REG_SWING_TIME: cfg_q.swing_ms   <= wdata_ms;
        REG_FLOOD_TIME: cfg_q.flood_ms   <= wdata_ms;
        REG_MIN_LEVEL:  cfg_q.min_level  <= cfg_wdata_i[LVL_W-1:0];
        REG_VAL_PERIOD: cfg_q.val_period <= cfg_wdata_i;
        default:        cfg_q            <= cfg_q;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: sv/isp_core.sv
`timescale 1ns / 1ps
// Input register, sequencer state and the per-word decision logic.
// Depends on isp_pkg and isp_if.
module isp_core #(
  parameter int unsigned TIME_BITS  = 32,
  parameter int unsigned LEVEL_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  isp_in_if.sink               in_i,
  input  isp_pkg::isp_cfg_t    cfg_i,
  input  logic                 free_i,   // result stage can take a bundle
  output logic                 push_o,
  output isp_pkg::isp_bundle_t bundle_o
);
  import isp_pkg::*;

  localparam int unsigned TW = (TIME_BITS < NOW_W) ? TIME_BITS : NOW_W;
  localparam int unsigned LW = (LEVEL_BITS < LVL_W) ? LEVEL_BITS : LVL_W;
  localparam int unsigned SW = ((TW > MS_W) ? TW : MS_W) + 1;

  // input register
  logic    in_vld_q;
  isp_in_t in_q;
  logic    fire;

  assign fire       = in_vld_q & free_i;
  assign in_i.ready = ~in_vld_q | fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.data;
    end
  end

  // sequencer state
  logic          irr_q, irr_d;
  logic          des_q, des_d;
  logic          act_q, act_d;
  logic [LW-1:0] lvl_q, lvl_d;
  logic          flt_q, flt_d;
  logic          swon_q, swon_d;
  logic          arm_q, arm_d;
  logic [TW-1:0] phase_q, phase_d;
  logic [TW-1:0] swst_q, swst_d;
  logic [SW-1:0] dline_q, dline_d;
  logic [TW-1:0] chk_q, chk_d;
  logic [TW-1:0] val_q, val_d;
  isp_flags_t    flg_q, flg_d;

  logic [TW-1:0]           now_t;
  logic [SW-1:0]           now_w;
  logic                    permit;
  logic                    run_timed, is_dam, is_swing;
  logic [MAX_RES-1:0][2:0] act_v;
  logic [1:0]              n_v;

  assign now_t     = in_q.now_ms[TW-1:0];
  assign now_w     = SW'(now_t);
  assign permit    = LVL_W'(lvl_q) > cfg_i.min_level;
  assign is_dam    = cfg_i.mode == MODE_DAM;
  assign is_swing  = cfg_i.mode == MODE_SWING;
  assign run_timed = (cfg_i.mode == MODE_NORMAL) || (cfg_i.mode == MODE_DRIP) ||
                     is_swing || is_dam;

  always_comb begin
    irr_d   = irr_q;
    des_d   = des_q;
    act_d   = act_q;
    lvl_d   = lvl_q;
    flt_d   = flt_q;
    swon_d  = swon_q;
    arm_d   = arm_q;
    phase_d = phase_q;
    swst_d  = swst_q;
    dline_d = dline_q;
    chk_d   = chk_q;
    val_d   = val_q;
    flg_d   = flg_q;
    act_v   = '0;
    n_v     = 2'd0;

    case (in_q.func)
      FUNC_TICK: begin
        if (cfg_i.enable && in_q.lower_present) begin
          // timed drainage / irrigation phases
          if (run_timed) begin
            if (irr_q) begin
              if (now_w > SW'(phase_q) + SW'(cfg_i.on_ms)) begin
                phase_d = now_t;
                if (is_dam) begin
                  act_v[n_v] = ACT_DAM_OPEN;
                  n_v        = n_v + 2'd1;
                end
                des_d      = 1'b0;
                act_v[n_v] = ACT_PUMP_OFF;
                n_v        = n_v + 2'd1;
                irr_d      = 1'b0;
              end else if (is_dam) begin
                if (flt_q) begin
                  des_d         = 1'b0;
                  act_v[0]      = ACT_PUMP_OFF;
                  act_v[1]      = ACT_DAM_CLOSE;
                  n_v           = 2'd2;
                end else if (now_w > dline_q) begin
                  des_d         = 1'b0;
                  act_v[0]      = ACT_PUMP_OFF;
                  act_v[1]      = ACT_DAM_OPEN;
                  n_v           = 2'd2;
                end
              end
            end else if (now_w > SW'(phase_q) + SW'(cfg_i.off_ms)) begin
              phase_d = now_t;
              if (is_dam) begin
                dline_d = now_w + SW'(cfg_i.flood_ms);
              end
              if (permit) begin
                des_d       = 1'b1;
                act_v[0]    = ACT_PUMP_ON;
                n_v         = 2'd1;
                irr_d       = 1'b1;
                flg_d.pno   = 1'b0;
                if (is_swing) begin
                  dline_d = now_w + SW'(cfg_i.flood_ms);
                  arm_d   = 1'b1;
                end
              end else begin
                flg_d.pno = 1'b1;
              end
            end
          end

          // swing refill, fill timing and upper unit presence
          if (is_swing && (now_w > SW'(chk_q) + SW'(CHECK_MS))) begin
            chk_d = now_t;
            if (in_q.system_ready && !in_q.upper_present) begin
              flg_d.dm = 1'b1;
              if (des_d) begin
                des_d      = 1'b0;
                act_v[n_v] = ACT_PUMP_OFF;
                n_v        = n_v + 2'd1;
              end
            end else if (irr_d) begin
              if (!swon_q && (now_w > SW'(swst_q) + SW'(cfg_i.swing_ms))) begin
                des_d      = 1'b1;
                act_v[n_v] = ACT_PUMP_ON;
                n_v        = n_v + 2'd1;
                swon_d     = 1'b1;
              end else if (swon_q && flt_q) begin
                des_d      = 1'b0;
                act_v[n_v] = ACT_PUMP_OFF;
                n_v        = n_v + 2'd1;
                swon_d     = 1'b0;
                swst_d     = now_t;
                if (arm_d && (now_w > dline_d)) begin
                  flg_d.late = 1'b1;
                end else begin
                  flg_d.late = 1'b0;
                  arm_d      = 1'b0;
                end
              end else if (swon_q && !permit) begin
                des_d      = 1'b0;
                act_v[n_v] = ACT_PUMP_OFF;
                n_v        = n_v + 2'd1;
                swon_d     = 1'b0;
                flg_d.pno  = 1'b1;
              end
            end
          end

          // pump command validator
          if ((cfg_i.mode != MODE_MAINT) &&
              (now_w > SW'(val_q) + SW'(cfg_i.val_period))) begin
            val_d = now_t;
            if (act_q != des_d) begin
              act_v[n_v] = des_d ? ACT_PUMP_ON : ACT_PUMP_OFF;
              n_v        = n_v + 2'd1;
            end
          end
        end else if (des_q) begin
          des_d    = 1'b0;
          act_v[0] = ACT_PUMP_OFF;
          act_v[1] = ACT_DAM_OPEN;
          n_v      = 2'd2;
        end
      end
      FUNC_LOWER: begin
        lvl_d = in_q.water_level[LW-1:0];
        act_d = in_q.pump_running;
      end
      FUNC_UPPER: begin
        flt_d = in_q.float_high;
      end
      FUNC_RESTART: begin
        phase_d  = now_t;
        swst_d   = now_t;
        dline_d  = '0;
        irr_d    = 1'b0;
        des_d    = 1'b0;
        act_v[0] = ACT_PUMP_OFF;
        act_v[1] = ACT_DAM_OPEN;
        n_v      = 2'd2;
      end
      default: begin
        flg_d = flg_q;
      end
    endcase

    // an item without commands still yields one word
    if (n_v == 2'd0) begin
      n_v = 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irr_q   <= 1'b0;
      des_q   <= 1'b0;
      act_q   <= 1'b0;
      lvl_q   <= '0;
      flt_q   <= 1'b0;
      swon_q  <= 1'b0;
      arm_q   <= 1'b0;
      phase_q <= '0;
      swst_q  <= '0;
      dline_q <= '0;
      chk_q   <= '0;
      val_q   <= '0;
      flg_q   <= '0;
    end else if (fire) begin
      irr_q   <= irr_d;
      des_q   <= des_d;
      act_q   <= act_d;
      lvl_q   <= lvl_d;
      flt_q   <= flt_d;
      swon_q  <= swon_d;
      arm_q   <= arm_d;
      phase_q <= phase_d;
      swst_q  <= swst_d;
      dline_q <= dline_d;
      chk_q   <= chk_d;
      val_q   <= val_d;
      flg_q   <= flg_d;
    end
  end

  assign push_o         = fire;
  assign bundle_o.acts  = act_v;
  assign bundle_o.cnt   = n_v;
  assign bundle_o.flags = flg_d;

endmodule

FILE: sv/isp_out.sv
`timescale 1ns / 1ps
// Result register: holds one item's command bundle and sends it a word a cycle while out ready is high.
// Depends on isp_pkg and isp_if.
module isp_out (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  isp_pkg::isp_bundle_t bundle_i,
  output logic                 free_o,
  isp_out_if.source            out_o
);
  import isp_pkg::*;

  logic        vld_q;
  logic [1:0]  idx_q;
  isp_bundle_t bnd_q;
  logic        is_last;

  assign is_last = idx_q == (bnd_q.cnt - 2'd1);
  assign free_o  = ~vld_q | (out_o.ready & is_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= 2'd0;
    end else if (push_i) begin
      vld_q <= 1'b1;
      idx_q <= 2'd0;
    end else if (vld_q && out_o.ready) begin
      if (is_last) begin
        vld_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      bnd_q <= bundle_i;
    end
  end

  assign out_o.valid                 = vld_q;
  assign out_o.data.action           = isp_act_e'(bnd_q.acts[idx_q]);
  assign out_o.data.pump_not_operate = bnd_q.flags.pno;
  assign out_o.data.tank_flood_late  = bnd_q.flags.late;
  assign out_o.data.device_mismatch  = bnd_q.flags.dm;
  assign out_o.data.last             = is_last;

endmodule

FILE: sv/irrigation_pump_sequencer.sv
`timescale 1ns / 1ps
// Irrigation pump and dam sequencer, top level.
// Depends on isp_pkg, isp_if, isp_cfg, isp_core and isp_out.
//
// Each input word (time tick, lower sensor update, upper sensor update or
// restart) is registered, then decided against the sequencer state: timed
// drainage/irrigation phases, swing refill and fill timing, dam control and
// the pump command validator. The decision yields one to three command words
// (pump off, pump on, open dam, close dam, or none), each carrying the status
// flags as they stand after the whole input word, with last set on the final
// one, and is loaded into the result register. The single result port sends
// one word per cycle while out ready is high, so an input word with more than
// one result holds the result register until its last word is taken; with no
// output stall the rate is one input word per cycle for single-result words.
// While results drain, the input register takes one further word and then
// holds ready low until the result register frees. Durations are programmed
// in seconds and scaled to ms on the register write; time sums are formed one
// bit wider than the wider of timestamps and ms durations, so they never wrap.
// Program registers only while the block is idle.
module irrigation_pump_sequencer #(
  parameter int unsigned TIME_BITS  = 32,  // 24..64, time values kept to this width, at most 32 bits
  parameter int unsigned LEVEL_BITS = 8    // 4..16, water level kept to this width, at most 8 bits
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [isp_pkg::CIDX_W-1:0] cfg_idx_i,
  input  logic [isp_pkg::CFG_W-1:0]  cfg_wdata_i,
  isp_in_if.sink                     in_i,
  isp_out_if.source                  out_o
);
  import isp_pkg::*;

  isp_cfg_t    cfg;
  logic        free;
  logic        push;
  isp_bundle_t bundle;

  // register file
  isp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // input register and decision logic
  isp_core #(
    .TIME_BITS  (TIME_BITS),
    .LEVEL_BITS (LEVEL_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cfg_i    (cfg),
    .free_i   (free),
    .push_o   (push),
    .bundle_o (bundle)
  );

  // result register and word sequencing
  isp_out u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .bundle_i (bundle),
    .free_o   (free),
    .out_o    (out_o)
  );

endmodule
